/* src/sbmd_pkg.sv */
// Shared widths, constants, types and helpers for the soft brush mask dab pipeline.
package sbmd_pkg;

  // Input position format and fixed register widths.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;
  localparam int CEN_W      = 17;
  localparam int RAD_W      = 16;
  localparam int HARD_W     = 9;
  localparam int MASK_W     = 8;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  // Geometry widths.
  localparam int POS_W  = COORD_BITS + FRAC_BITS;
  localparam int DIFF_W = ((POS_W > CEN_W) ? POS_W : CEN_W) + 2;
  localparam int ABS_W  = DIFF_W - 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int DSQ_W  = SQ_W + 1;
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int RH_W   = RAD_W + HARD_W;

  // Intensity is Q1.16; squares are aligned to the core square format.
  localparam int INT_FRAC   = 16;
  localparam int INT_W      = INT_FRAC + 1;
  localparam int QUO_W      = INT_FRAC;
  localparam int BIG_W      = RSQ_W + INT_FRAC;
  localparam int DROP_SHIFT = 2 * FRAC_BITS;
  localparam int Q8_SHIFT   = 8;

  // Blend arithmetic widths.
  localparam int PROD_W  = MASK_W + INT_W;
  localparam int BLEND_W = MASK_W + INT_FRAC + 2;

  localparam logic [DIFF_W-1:0]  HALF_POS  = DIFF_W'(1 << (FRAC_BITS - 1));
  localparam logic [INT_W-1:0]   ONE_Q16   = {1'b1, {INT_FRAC{1'b0}}};
  localparam logic [HARD_W-1:0]  Q8_ONE    = HARD_W'(256);
  localparam logic [MASK_W-1:0]  MASK_MAX  = {MASK_W{1'b1}};
  localparam logic [BLEND_W-1:0] ROUND_Q16 = BLEND_W'(1 << (INT_FRAC - 1));
  // Largest span that still counts as degenerate: span * 10000 <= 2^(2F+16).
  localparam logic [BIG_W-1:0]   DEGEN_MAX =
    BIG_W'((64'd1 << (2 * FRAC_BITS + INT_FRAC)) / 64'd10000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CX       = 3'd0,
    CFG_CY       = 3'd1,
    CFG_RADIUS   = 3'd2,
    CFG_HARDNESS = 3'd3,
    CFG_OPACITY  = 3'd4,
    CFG_ERASE    = 3'd5
  } cfg_idx_t;

  // Stroke settings; cx and cy hold two's complement Q.FRAC_BITS values.
  typedef struct packed {
    logic [CEN_W-1:0]  cx;
    logic [CEN_W-1:0]  cy;
    logic [RAD_W-1:0]  rad;
    logic [HARD_W-1:0] hard;
    logic [HARD_W-1:0] opac;
    logic              erase;
  } cfg_t;

  // Per-pixel flags and values that ride alongside the divider.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              in_disk;
    logic              in_core;
    logic              degen;
    logic [INT_W-1:0]  inten_deg;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [BIG_W-1:0] num;
    logic [BIG_W-1:0] span;
  } geo_t;

  typedef struct packed {
    side_t            side;
    logic [QUO_W-1:0] quo;
  } div_t;

  // Hardness and opacity above one are treated as one.
  function automatic logic [HARD_W-1:0] sat_q8(input logic [HARD_W-1:0] x);
    return (x > Q8_ONE) ? Q8_ONE : x;
  endfunction

endpackage

/* src/sbmd_geom.sv */
// Front pipeline: offsets, squares, radius and core tests, falloff operands.
module sbmd_geom
  import sbmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [MASK_W-1:0]     mask_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output geo_t                  out_word
);

  function automatic logic [ABS_W-1:0] offset_mag(input logic [COORD_BITS-1:0] p,
                                                  input logic [CEN_W-1:0] c);
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] n;
    d = {{(DIFF_W - POS_W){1'b0}}, p, {FRAC_BITS{1'b0}}} + HALF_POS
        - {{(DIFF_W - CEN_W){c[CEN_W-1]}}, c};
    n = ~d + 1'b1;
    return d[DIFF_W-1] ? n[ABS_W-1:0] : d[ABS_W-1:0];
  endfunction

  logic en;

  // Stage 1
  logic              v1, rz1;
  logic [ABS_W-1:0]  ax1, ay1;
  logic [RSQ_W-1:0]  rsq1, rsq1_next;
  logic [RH_W-1:0]   rh1, rh1_next;
  logic [MASK_W-1:0] mv1;
  // Stage 2
  logic              v2, rz2;
  logic [SQ_W-1:0]   sqx2, sqy2;
  logic [BIG_W-1:0]  core2;
  logic [RSQ_W-1:0]  rsq2;
  logic [MASK_W-1:0] mv2;
  logic [2*RH_W-1:0] core_full;
  // Stage 3
  logic              v3, rz3;
  logic [DSQ_W-1:0]  dsq3;
  logic [BIG_W-1:0]  bigr3, core3, span3;
  logic [RSQ_W-1:0]  rsq3;
  logic [MASK_W-1:0] mv3;
  logic [BIG_W-1:0]  bigr_next;
  // Stage 4
  logic              v4, ins4, hit4, dg4;
  logic [BIG_W-1:0]  num4, drop4, span4;
  logic [MASK_W-1:0] mv4;
  logic [BIG_W-1:0]  bigd, dmc;
  // Stage 5
  logic              v5, ins5, hit5, dg5;
  logic [INT_W-1:0]  deg5, deg_next;
  logic [BIG_W-1:0]  num5, span5;
  logic [MASK_W-1:0] mv5;

  assign en       = !v5 || out_ready;
  assign in_ready = en;

  always_comb begin
    rsq1_next = cfg.rad * cfg.rad;
    rh1_next  = cfg.rad * sat_q8(cfg.hard);
    core_full = rh1 * rh1;
    bigr_next = {rsq2, {INT_FRAC{1'b0}}};
    bigd      = {dsq3[RSQ_W-1:0], {INT_FRAC{1'b0}}};
    dmc       = bigd - core3;
    deg_next  = (drop4 >= BIG_W'(ONE_Q16)) ? '0 : ONE_Q16 - drop4[INT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1   <= offset_mag(pixel_x, cfg.cx);
      ay1   <= offset_mag(pixel_y, cfg.cy);
      rsq1  <= rsq1_next;
      rh1   <= rh1_next;
      rz1   <= (cfg.rad == '0);
      mv1   <= mask_value;

      sqx2  <= ax1 * ax1;
      sqy2  <= ay1 * ay1;
      core2 <= core_full[BIG_W-1:0];
      rsq2  <= rsq1;
      rz2   <= rz1;
      mv2   <= mv1;

      dsq3  <= {1'b0, sqx2} + {1'b0, sqy2};
      bigr3 <= bigr_next;
      core3 <= core2;
      span3 <= bigr_next - core2;
      rsq3  <= rsq2;
      rz3   <= rz2;
      mv3   <= mv2;

      ins4  <= !rz3 && (dsq3 <= {{(DSQ_W - RSQ_W){1'b0}}, rsq3});
      hit4  <= (bigd <= core3);
      dg4   <= (span3 <= DEGEN_MAX);
      num4  <= bigr3 - bigd;
      drop4 <= dmc >> DROP_SHIFT;
      span4 <= span3;
      mv4   <= mv3;

      ins5  <= ins4;
      hit5  <= hit4;
      dg5   <= dg4;
      deg5  <= deg_next;
      num5  <= num4;
      span5 <= span4;
      mv5   <= mv4;
    end
  end

  assign out_valid               = v5;
  assign out_word.side.mask      = mv5;
  assign out_word.side.in_disk   = ins5;
  assign out_word.side.in_core   = hit5;
  assign out_word.side.degen     = dg5;
  assign out_word.side.inten_deg = deg5;
  assign out_word.num            = num5;
  assign out_word.span           = span5;

endmodule

/* src/sbmd_div.sv */
// Pipelined restoring divider: one quotient bit of the falloff per stage.
module sbmd_div
  import sbmd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  geo_t in_word,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_word
);

  localparam int N = QUO_W;

  logic             en;
  logic [N-1:0]     vld;
  logic [BIG_W-1:0] rem  [N];
  logic [BIG_W-1:0] span [N];
  logic [QUO_W-1:0] quo  [N];
  side_t            side [N];

  logic [BIG_W-1:0] src_rem  [N];
  logic [BIG_W-1:0] src_span [N];
  logic [QUO_W-1:0] src_quo  [N];
  side_t            src_side [N];
  logic [BIG_W-1:0] nxt_rem  [N];
  logic [QUO_W-1:0] nxt_quo  [N];

  assign en       = !vld[N-1] || out_ready;
  assign in_ready = en;

  // The numerator is below the span whenever the quotient is used, so the
  // partial remainder always fits the span width.
  always_comb begin
    logic [BIG_W:0] t;
    logic [BIG_W:0] d;
    logic           ge;
    src_rem[0]  = in_word.num;
    src_span[0] = in_word.span;
    src_quo[0]  = '0;
    src_side[0] = in_word.side;
    for (int i = 1; i < N; i++) begin
      src_rem[i]  = rem[i-1];
      src_span[i] = span[i-1];
      src_quo[i]  = quo[i-1];
      src_side[i] = side[i-1];
    end
    for (int i = 0; i < N; i++) begin
      t          = {src_rem[i], 1'b0};
      d          = t - {1'b0, src_span[i]};
      ge         = (t >= {1'b0, src_span[i]});
      nxt_rem[i] = ge ? d[BIG_W-1:0] : t[BIG_W-1:0];
      nxt_quo[i] = {src_quo[i][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem[i]  <= nxt_rem[i];
        span[i] <= src_span[i];
        quo[i]  <= nxt_quo[i];
        side[i] <= src_side[i];
      end
    end
  end

  assign out_valid     = vld[N-1];
  assign out_word.side = side[N-1];
  assign out_word.quo  = quo[N-1];

endmodule

/* src/sbmd_blend.sv */
// Back pipeline: intensity select, opacity scaling, blend, rounding and clamp.
module sbmd_blend
  import sbmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  div_t              in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] new_mask_value,
  output logic              inside_brush
);

  logic en;

  // Stage A
  logic                      va, ins_a, ers_a, oz_a;
  logic [MASK_W-1:0]         mv_a;
  logic [INT_W-1:0]          scl_a;
  logic [INT_W-1:0]          inten_sel;
  logic [INT_W+HARD_W-1:0]   scl_full;
  // Stage B
  logic                      vb, ins_b, ers_b, oz_b;
  logic [MASK_W-1:0]         mv_b, mul_b;
  logic [PROD_W-1:0]         prod_b;
  // Stage C
  logic                      vc, ins_c, ers_c, oz_c;
  logic [MASK_W-1:0]         mv_c, res_c, res_next;
  logic [BLEND_W-1:0]        base, paint_sum, erase_sum;

  assign en       = !vc || out_ready;
  assign in_ready = en;

  always_comb begin
    if (in_word.side.in_core) begin
      inten_sel = ONE_Q16;
    end else if (in_word.side.degen) begin
      inten_sel = in_word.side.inten_deg;
    end else begin
      inten_sel = {1'b0, in_word.quo};
    end
    scl_full = inten_sel * sat_q8(cfg.opac);
    mul_b    = ers_a ? mv_a : MASK_MAX - mv_a;

    base      = {{(BLEND_W - MASK_W - INT_FRAC){1'b0}}, mv_b, {INT_FRAC{1'b0}}};
    paint_sum = base + {{(BLEND_W - PROD_W){1'b0}}, prod_b} + ROUND_Q16;
    erase_sum = base - {{(BLEND_W - PROD_W){1'b0}}, prod_b} + ROUND_Q16;
    if (!ins_b) begin
      res_next = mv_b;
    end else if (ers_b) begin
      res_next = erase_sum[INT_FRAC +: MASK_W];
    end else if (|paint_sum[BLEND_W-1:INT_FRAC+MASK_W]) begin
      res_next = MASK_MAX;
    end else begin
      res_next = paint_sum[INT_FRAC +: MASK_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mv_a   <= in_word.side.mask;
      ins_a  <= in_word.side.in_disk;
      ers_a  <= cfg.erase;
      oz_a   <= (cfg.opac == '0);
      scl_a  <= scl_full[Q8_SHIFT +: INT_W];

      mv_b   <= mv_a;
      ins_b  <= ins_a;
      ers_b  <= ers_a;
      oz_b   <= oz_a;
      prod_b <= mul_b * scl_a;

      mv_c   <= mv_b;
      ins_c  <= ins_b;
      ers_c  <= ers_b;
      oz_c   <= oz_b;
      res_c  <= res_next;
    end
  end

  assign out_valid      = vc;
  assign new_mask_value = res_c;
  assign inside_brush   = ins_c;

`ifndef SYNTHESIS
  a_outside_keeps: assert property (@(posedge clk) disable iff (rst)
    vc && !ins_c |-> res_c == mv_c)
    else $error("pixel outside the brush was changed");

  a_erase_lowers: assert property (@(posedge clk) disable iff (rst)
    vc && ins_c && ers_c |-> res_c <= mv_c)
    else $error("erase raised a mask value");

  a_paint_raises: assert property (@(posedge clk) disable iff (rst)
    vc && ins_c && !ers_c |-> res_c >= mv_c)
    else $error("paint lowered a mask value");

  a_zero_opacity: assert property (@(posedge clk) disable iff (rst)
    vc && ins_c && oz_c |-> res_c == mv_c)
    else $error("zero opacity changed a mask value");
`endif

endmodule

/* src/soft_brush_mask_dab.sv */
// Top level of the soft round brush dab: stroke registers and the pixel pipeline.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_ready  pixel_x, pixel_y, mask_value
//   out       output     out_valid/out_ready  new_mask_value, inside_brush
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// The block takes one word per cycle while in_ready is high; each result passes
// through 5 stages of geometry, 16 divider stages (one quotient bit each, set
// by the per-bit subtract and compare over the span width) and 3 blend stages.
// Reset clears every pipeline valid bit and returns the stroke registers to
// radius 0, hardness and opacity one, center zero and paint mode.
// Each of the three sections holds only when its last stage is full and the
// next section refuses; it then waits as a whole, empty slots included, so only
// an empty last stage lets words move up during a stall.
module soft_brush_mask_dab
  import sbmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [MASK_W-1:0]     mask_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MASK_W-1:0]     new_mask_value,
  output logic                  inside_brush,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Stroke settings, read directly by every pipeline stage while words are in
  // flight. The user must write them between strokes only; nothing checks it.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cx    <= '0;
      cfg.cy    <= '0;
      cfg.rad   <= '0;
      cfg.hard  <= Q8_ONE;
      cfg.opac  <= Q8_ONE;
      cfg.erase <= 1'b0;
    end else if (cfg_we) begin
      // Indexes past the last register are dropped.
      unique case (cfg_idx_t'(cfg_index))
        CFG_CX:       cfg.cx    <= cfg_data[CEN_W-1:0];
        CFG_CY:       cfg.cy    <= cfg_data[CEN_W-1:0];
        CFG_RADIUS:   cfg.rad   <= cfg_data[RAD_W-1:0];
        CFG_HARDNESS: cfg.hard  <= cfg_data[HARD_W-1:0];
        CFG_OPACITY:  cfg.opac  <= cfg_data[HARD_W-1:0];
        CFG_ERASE:    cfg.erase <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Geometry: offsets from the brush center to the pixel center, squared
  // distance, radius and core tests, and the falloff numerator and span.
  logic geo_valid, geo_ready;
  geo_t geo_word;

  sbmd_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .mask_value (mask_value),
    .out_valid  (geo_valid),
    .out_ready  (geo_ready),
    .out_word   (geo_word)
  );

  // Linear falloff in squared distance: (R - D) * 2^16 / (R - C), one bit per
  // stage. Pixels in the core or with a degenerate span ignore the quotient.
  logic div_valid, div_ready;
  div_t div_word;

  sbmd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (geo_valid),
    .in_ready  (geo_ready),
    .in_word   (geo_word),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_word  (div_word)
  );

  // Opacity scaling and the blend toward 255 or 0 with rounding; the last
  // blend stage is the output register.
  sbmd_blend u_blend (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (div_valid),
    .in_ready       (div_ready),
    .in_word        (div_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .new_mask_value (new_mask_value),
    .inside_brush   (inside_brush)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the soft round brush dab on 8-bit mask pixels.
module tb_top;
  import sbmd_pkg::*;

  // Register indexes past the last stroke register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  // Fixed-point constants of the intensity and blend arithmetic.
  localparam longint unsigned UNIT_Q16    = 64'd65536;
  localparam longint unsigned ROUND_Q16H  = 64'd32768;
  localparam longint unsigned DEGEN_SCALE = 64'd10000;
  localparam longint unsigned DEGEN_REF   = 64'd1 << (2 * FRAC_BITS + 16);
  localparam longint unsigned Q8_UNIT     = 64'd256;

  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // The pipeline is 24 stages deep; this covers it with margin.
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [MASK_W-1:0] value;
    logic              in_brush;
  } dab_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_BITS-1:0] pixel_x = '0;
  logic [COORD_BITS-1:0] pixel_y = '0;
  logic [MASK_W-1:0]     mask_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [MASK_W-1:0]     new_mask_value;
  logic                  inside_brush;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our own copy of the stroke registers, updated as each write lands.
  cfg_t        stroke;
  // Dab results still owed by the block, oldest first.
  dab_result_t pending_dabs[$];
  dab_result_t head_dab;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  // Percent chance per word of starting an idle burst; zero means no idling.
  int          idle_rate = 0;

  soft_brush_mask_dab dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .mask_value    (mask_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_mask_value(new_mask_value),
    .inside_brush  (inside_brush),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Dab arithmetic for one pixel under the given stroke. Squares are kept exact in
  // 64 bits; the core square and the shifted distance and radius squares share the
  // Q.(2F+16) format so the falloff divide works on integers only.
  function automatic dab_result_t predict_dab(input cfg_t s,
                                              input logic [COORD_BITS-1:0] px,
                                              input logic [COORD_BITS-1:0] py,
                                              input logic [MASK_W-1:0] v);
    longint          dx, dy;
    longint unsigned hard, opac, rad, mv, dsq, rsq, core, big_r, big_d, span, inten;
    longint unsigned drop, blend;
    dab_result_t     r;
    r.value    = v;
    r.in_brush = 1'b0;
    rad  = 64'(s.rad);
    mv   = 64'(v);
    // Hardness and opacity above one saturate at one.
    hard = (s.hard > Q8_UNIT) ? Q8_UNIT : 64'(s.hard);
    opac = (s.opac > Q8_UNIT) ? Q8_UNIT : 64'(s.opac);
    // A zero radius leaves every pixel alone.
    if (rad == 0) return r;
    // Offsets are taken from the pixel center, half a pixel in on both axes.
    dx = (longint'(px) <<< FRAC_BITS) + (longint'(1) <<< (FRAC_BITS - 1))
         - longint'($signed(s.cx));
    dy = (longint'(py) <<< FRAC_BITS) + (longint'(1) <<< (FRAC_BITS - 1))
         - longint'($signed(s.cy));
    dsq = longint'(dx * dx + dy * dy);
    rsq = rad * rad;
    if (dsq > rsq) return r;
    r.in_brush = 1'b1;
    core  = rad * hard;
    core  = core * core;
    big_r = rsq << 16;
    big_d = dsq << 16;
    if (big_d <= core) begin
      inten = UNIT_Q16;
    end else begin
      span = big_r - core;
      if (span * DEGEN_SCALE > DEGEN_REF) begin
        inten = ((big_r - big_d) << 16) / span;
      end else begin
        // Falloff span too narrow to divide by: the reciprocal is taken as one.
        drop  = (big_d - core) >> (2 * FRAC_BITS);
        inten = (drop >= UNIT_Q16) ? 64'd0 : UNIT_Q16 - drop;
      end
    end
    inten = (inten * opac) >> 8;
    if (s.erase) begin
      blend   = (mv << 16) - mv * inten + ROUND_Q16H;
      r.value = blend[23:16];
    end else begin
      blend   = ((mv << 16) + (64'd255 - mv) * inten + ROUND_Q16H) >> 16;
      r.value = (blend > 64'd255) ? MASK_MAX : blend[7:0];
    end
    return r;
  endfunction

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Result side: compares each accepted word with the oldest pending dab and
  // throws random back-pressure bursts.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_dabs.size() == 0) begin
        note_error($sformatf("result with nothing pending: value %0d in_brush %0b",
                             new_mask_value, inside_brush));
      end else begin
        head_dab = pending_dabs.pop_front();
        if (new_mask_value !== head_dab.value)
          note_error($sformatf("new_mask_value expected %0d got %0d",
                               head_dab.value, new_mask_value));
        if (inside_brush !== head_dab.in_brush)
          note_error($sformatf("inside_brush expected %0b got %0b",
                               head_dab.in_brush, inside_brush));
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_rate != 0 && $urandom_range(99) < idle_rate) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a correct run never goes this long without moving a word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // One register write. Our copy is updated only at the edge the block takes it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CX:       stroke.cx    = data[CEN_W-1:0];
      CFG_CY:       stroke.cy    = data[CEN_W-1:0];
      CFG_RADIUS:   stroke.rad   = data[RAD_W-1:0];
      CFG_HARDNESS: stroke.hard  = data[HARD_W-1:0];
      CFG_OPACITY:  stroke.opac  = data[HARD_W-1:0];
      CFG_ERASE:    stroke.erase = data[0];
      default: ;
    endcase
  endtask

  task automatic set_stroke(input logic [CEN_W-1:0] cx, input logic [CEN_W-1:0] cy,
                            input logic [RAD_W-1:0] rad, input logic [HARD_W-1:0] hard,
                            input logic [HARD_W-1:0] opac, input logic erase);
    write_reg(CFG_CX, cx);
    write_reg(CFG_CY, cy);
    write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
    write_reg(CFG_HARDNESS, CFG_DATA_W'(hard));
    write_reg(CFG_OPACITY, CFG_DATA_W'(opac));
    write_reg(CFG_ERASE, CFG_DATA_W'(erase));
  endtask

  // Offers one pixel word and returns at the edge where it is taken. Valid stays
  // high afterwards so the next word can follow back to back.
  task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                            input logic [MASK_W-1:0] v);
    if (idle_rate != 0 && $urandom_range(99) < idle_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    pixel_x    <= px;
    pixel_y    <= py;
    mask_value <= v;
    do @(posedge clk); while (!in_ready);
    pending_dabs.push_back(predict_dab(stroke, px, py, v));
  endtask

  // Lowers valid and waits until every pending dab has come back, so the block is
  // idle and the stroke registers may change.
  task automatic drain_dabs();
    in_valid <= 1'b0;
    while (pending_dabs.size() != 0) @(posedge clk);
  endtask

  // After reset the radius is zero: pixels pass through and are flagged outside.
  task automatic test_idle_stroke();
    send_pixel(12'd0, 12'd0, 8'd100);
    send_pixel(12'hFFF, 12'hFFF, 8'hFF);
    drain_dabs();
  endtask

  // Brush centered on pixel (10,10), radius 5 pixels, half hard: center, core,
  // falloff, exactly on the rim and just outside.
  task automatic test_paint_profile();
    set_stroke(17'd168, 17'd168, 16'd80, 9'd128, 9'd256, 1'b0);
    send_pixel(12'd10, 12'd10, 8'd0);
    send_pixel(12'd11, 12'd10, 8'd37);
    send_pixel(12'd13, 12'd10, 8'd200);
    send_pixel(12'd15, 12'd10, 8'd0);
    send_pixel(12'd16, 12'd10, 8'd255);
    drain_dabs();
  endtask

  task automatic test_erase_profile();
    write_reg(CFG_ERASE, 17'd1);
    send_pixel(12'd10, 12'd10, 8'd255);
    send_pixel(12'd13, 12'd10, 8'd128);
    send_pixel(12'd15, 12'd10, 8'd1);
    drain_dabs();
  endtask

  // Zero opacity leaves the pixel as is but still flags it inside; zero hardness
  // makes the whole disk a falloff.
  task automatic test_zero_hard_and_opacity();
    set_stroke(17'd168, 17'd168, 16'd80, 9'd0, 9'd0, 1'b0);
    send_pixel(12'd10, 12'd10, 8'd50);
    drain_dabs();
    write_reg(CFG_OPACITY, 17'd256);
    send_pixel(12'd12, 12'd11, 8'd50);
    drain_dabs();
  endtask

  // Hardness and opacity above one behave as one.
  task automatic test_saturated_q8();
    set_stroke(17'd168, 17'd168, 16'd80, 9'd511, 9'd300, 1'b0);
    send_pixel(12'd14, 12'd10, 8'd9);
    drain_dabs();
    write_reg(CFG_ERASE, 17'd1);
    send_pixel(12'd10, 12'd13, 8'd250);
    drain_dabs();
  endtask

  // A one-sixteenth pixel radius at nearly full hardness leaves a falloff span too
  // narrow to divide by; the pixel one step off center lands in it.
  task automatic test_narrow_falloff();
    set_stroke(17'd9, 17'd8, 16'd1, 9'd255, 9'd256, 1'b0);
    send_pixel(12'd0, 12'd0, 8'd0);
    drain_dabs();
    write_reg(CFG_CX, 17'd8);
    write_reg(CFG_HARDNESS, 17'd256);
    send_pixel(12'd0, 12'd0, 8'd3);
    drain_dabs();
  endtask

  // Centers at both ends of their range with the largest radius, plus writes to
  // the unused register indexes, which must change nothing.
  task automatic test_canvas_extremes();
    set_stroke(17'h0FFFF, 17'h0FFFF, 16'hFFFF, 9'd0, 9'd256, 1'b0);
    write_reg(CFG_SPARE_A, 17'h1FFFF);
    write_reg(CFG_SPARE_B, 17'd0);
    send_pixel(12'hFFF, 12'hFFF, 8'd0);
    send_pixel(12'd0, 12'hFFF, 8'd0);
    send_pixel(12'd0, 12'd0, 8'd128);
    drain_dabs();
    write_reg(CFG_CX, 17'h10000);
    write_reg(CFG_CY, 17'h10000);
    send_pixel(12'd0, 12'd0, 8'd77);
    drain_dabs();
  endtask

  function automatic logic [CEN_W-1:0] pick_center();
    case ($urandom_range(3))
      0:       return CEN_W'($urandom);
      3:       case ($urandom_range(2))
                 0:       return 17'h10000;
                 1:       return 17'h0FFFF;
                 default: return '0;
               endcase
      default: return CEN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [HARD_W-1:0] pick_q8();
    case ($urandom_range(5))
      0:       return '0;
      1:       return Q8_ONE;
      2:       return HARD_W'($urandom_range(257, 511));
      default: return HARD_W'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] pick_radius();
    case ($urandom_range(5))
      0:       return '0;
      1:       return RAD_W'($urandom_range(1, 64));
      2:       return RAD_W'($urandom_range(16, 1024));
      3:       return RAD_W'($urandom_range(1024, 16384));
      4:       return '1;
      default: return RAD_W'($urandom);
    endcase
  endfunction

  // Coordinate within reach of the brush on one axis, clipped to the canvas.
  function automatic logic [COORD_BITS-1:0] near_axis(input logic [CEN_W-1:0] c);
    int mid, reach, pos;
    mid   = int'($signed(c)) >>> FRAC_BITS;
    reach = int'(stroke.rad >> FRAC_BITS) + 1;
    pos   = mid + int'($urandom_range(2 * reach)) - reach;
    if (pos < 0) pos = 0;
    if (pos > 4095) pos = 4095;
    return COORD_BITS'(pos);
  endfunction

  // Random strokes, each followed by a batch of pixels. Most pixels fall on or
  // near the disk so the core, falloff and rim all get work; the rest are spread
  // over the whole canvas. The last stroke runs with no idling at all.
  task automatic test_random_strokes(input int strokes, input int per_stroke);
    logic [COORD_BITS-1:0] px, py;
    logic [MASK_W-1:0]     v;
    for (int s = 0; s < strokes; s++) begin
      set_stroke(pick_center(), pick_center(), pick_radius(), pick_q8(), pick_q8(),
                 1'($urandom_range(1)));
      case ($urandom_range(3))
        0:       idle_rate = 0;
        1:       idle_rate = 5;
        2:       idle_rate = 20;
        default: idle_rate = 40;
      endcase
      if (s == strokes - 1) idle_rate = 0;
      for (int i = 0; i < per_stroke; i++) begin
        if ($urandom_range(4) == 0) begin
          px = COORD_BITS'($urandom);
          py = COORD_BITS'($urandom);
        end else begin
          px = near_axis(stroke.cx);
          py = near_axis(stroke.cy);
        end
        case ($urandom_range(9))
          0:       v = '0;
          1:       v = MASK_MAX;
          default: v = MASK_W'($urandom);
        endcase
        send_pixel(px, py, v);
      end
      drain_dabs();
    end
  endtask

  initial begin
    stroke.cx    = '0;
    stroke.cy    = '0;
    stroke.rad   = '0;
    stroke.hard  = Q8_ONE;
    stroke.opac  = Q8_ONE;
    stroke.erase = 1'b0;
    repeat (10) @(posedge clk);
    rst       <= 1'b0;
    idle_rate = 15;
    test_idle_stroke();
    test_paint_profile();
    test_erase_profile();
    test_zero_hard_and_opacity();
    test_saturated_q8();
    test_narrow_falloff();
    test_canvas_extremes();
    test_random_strokes(9, 110);
    drain_dabs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dabs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
src/sbmd_pkg.sv
src/sbmd_geom.sv
src/sbmd_div.sv
src/sbmd_blend.sv
src/soft_brush_mask_dab.sv
test/tb_top.sv
